/* design/tpcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_pkg: shared types and constants of the two-priority command dispatcher
// Command, stream item, result and configuration types, the codes used on
// the channels, the commands injected by the block and the default depths.
// ----------------------------------------------------------------------------
package tpcd_pkg;

	// Default queue depths, handed to the top level parameters.
	localparam int URGENT_DEPTH_DEF = 8;
	localparam int NORMAL_DEPTH_DEF = 16;

	// Stream widths that do not depend on the queue depths.
	localparam int IN_TDATA_W = 40;
	localparam int IN_TUSER_W = 2;
	localparam int OUT_TUSER_W = 2;
	localparam int OUT_FIXED_W = 35;

	// Timer widths: 8 bit duration times 16 bit tick count.
	localparam int REM_W = 24;
	localparam int HOLD_W = 24;

	localparam logic [6:0] BATTERY_FULL = 7'd100;

	localparam logic [2:0] TYPE_REVERSE = 3'd2;
	localparam logic [2:0] TYPE_STOP = 3'd5;
	localparam logic [2:0] TYPE_CHARGE = 3'd6;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_PUSH_NORMAL = 2'd1,
		KIND_PUSH_URGENT = 2'd2,
		KIND_OBSTACLE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_STARTED = 2'd1,
		EV_FINISHED = 2'd2,
		EV_DROPPED = 2'd3
	} ev_t;

	typedef enum logic [1:0] {
		REG_TICKS_PER_UNIT = 2'd0,
		REG_BATTERY_COST = 2'd1,
		REG_LOW_BATTERY = 2'd2,
		REG_HOLD_UNITS = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_POP_RD,
		BK_POP_LD,
		BK_OBS2
	} bk_state_t;

	typedef struct packed {
		logic [15:0] id;
		logic [2:0] ctype;
		logic [7:0] dur;
		logic [6:0] speed;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		cmd_t cmd;
	} item_t;

	typedef struct packed {
		logic [15:0] ticks_per_unit;
		logic [6:0] battery_cost;
		logic [6:0] low_battery_level;
		logic [7:0] obstacle_hold_units;
	} cfg_t;

	typedef struct packed {
		ev_t ev;
		logic [15:0] id;
		logic [2:0] ctype;
		logic [6:0] speed;
		logic urgent;
		logic busy;
		logic [6:0] battery;
		logic alert;
	} res_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	localparam cmd_t CMD_RECHARGE = '{id: 16'd777, ctype: TYPE_CHARGE,
		dur: 8'd5, speed: 7'd100};
	localparam cmd_t CMD_STOP = '{id: 16'd999, ctype: TYPE_STOP,
		dur: 8'd1, speed: 7'd0};
	localparam cmd_t CMD_REVERSE = '{id: 16'd998, ctype: TYPE_REVERSE,
		dur: 8'd2, speed: 7'd50};

endpackage
`default_nettype wire

/* design/two_priority_command_dispatcher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// two_priority_command_dispatcher: strict-priority two-queue command scheduler
// Urgent and normal command FIFOs, a command timer, battery bookkeeping with
// injected recharge commands and obstacle handling with a hold window.
// ----------------------------------------------------------------------------
// Usage. Each input transfer carries one item: a tick, a push into the normal
// or urgent queue, or an obstacle event; the kind travels on s_axis_tuser.
// Every item yields exactly one result transfer on the master side, in item
// order, carrying the event code on m_axis_tuser and the active command,
// battery, queue occupancies and alert flag on m_axis_tdata.
// The user must write the configuration registers through cfg_we, cfg_addr and
// cfg_wdata only while the block is idle; the block itself does not enforce this. They take effect at once.
// Throughput: an item passes a two-entry input queue, then the execution
// sequencer. A push, a tick that does not start a command and a held
// obstacle each pass only the idle state of the sequencer, so they stream at
// one item per cycle while the receiver takes each result. A tick that
// starts a command passes the queue read, registered RAM data and timer load
// steps in turn, and an obstacle that injects its two commands passes two
// states, because the urgent queue has a single write port.
// Reset clears both queues, the timer and the active command, sets the
// battery to 100 and the registers to their defaults. When the receiver
// stalls, the result is held in the output register and the input queue
// keeps accepting until its two entries are full.
// ----------------------------------------------------------------------------
module two_priority_command_dispatcher #(
	parameter int URGENT_DEPTH = tpcd_pkg::URGENT_DEPTH_DEF,
	parameter int NORMAL_DEPTH = tpcd_pkg::NORMAL_DEPTH_DEF,
	localparam int UCW = $clog2(URGENT_DEPTH + 1),
	localparam int NCW = $clog2(NORMAL_DEPTH + 1),
	localparam int OUT_BITS = tpcd_pkg::OUT_FIXED_W + NCW + UCW + 1,
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
	input wire logic clk,
	input wire logic arst_n,
	// Input stream.
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// From bit 0: cmd_id[15:0], cmd_type[18:16], cmd_duration[26:19],
	// cmd_speed[33:27], zero padding.
	input wire logic [tpcd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// From bit 0: kind[1:0].
	input wire logic [tpcd_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	// Result stream.
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// From bit 0: active_id, active_type, active_speed, active_urgent,
	// busy_res, battery_level, normal_count, urgent_count, low_battery_alert,
	// zero padding.
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// From bit 0: event_res[1:0].
	output logic [tpcd_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
	// Configuration write port.
	input wire logic cfg_we,
	input wire logic [1:0] cfg_addr,
	input wire logic [15:0] cfg_wdata
);
	import tpcd_pkg::*;

	cfg_t cfg_q;
	logic item_valid;
	logic item_pop;
	item_t item;
	res_t res;
	logic [NCW-1:0] normal_count;
	logic [UCW-1:0] urgent_count;

	// Configuration registers. Each takes the low bits of the written word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_unit <= 16'd60;
			cfg_q.battery_cost <= 7'd15;
			cfg_q.low_battery_level <= 7'd20;
			cfg_q.obstacle_hold_units <= 8'd5;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_TICKS_PER_UNIT: cfg_q.ticks_per_unit <= cfg_wdata;
				REG_BATTERY_COST: cfg_q.battery_cost <= cfg_wdata[6:0];
				REG_LOW_BATTERY: cfg_q.low_battery_level <= cfg_wdata[6:0];
				REG_HOLD_UNITS: cfg_q.obstacle_hold_units <= cfg_wdata[7:0];
			endcase
		end
	end

	// Front end: accepts transfers and decodes the kind.
	tpcd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.item_valid(item_valid),
		.item(item),
		.item_pop(item_pop)
	);

	// Back end: queues, timer, battery and the result register.
	tpcd_back #(
		.URGENT_DEPTH(URGENT_DEPTH),
		.NORMAL_DEPTH(NORMAL_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item_valid(item_valid),
		.item(item),
		.item_pop(item_pop),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.res(res),
		.normal_count(normal_count),
		.urgent_count(urgent_count)
	);

	assign m_axis_tuser = res.ev;
	assign m_axis_tdata = OUT_TDATA_W'({res.alert, urgent_count, normal_count,
		res.battery, res.busy, res.urgent, res.speed, res.ctype, res.id});

	// The back end only takes an item when the result register can take
	// its result.
	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> (!m_axis_tvalid || m_axis_tready))
		else $error("item taken while the result register is blocked");

	// A started command is always reported as executing.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (res.ev == EV_STARTED)) |-> res.busy)
		else $error("started command not marked busy");

	// Battery arithmetic saturates and never exceeds a full charge.
	a_battery_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.battery <= BATTERY_FULL))
		else $error("battery level out of range");

	// Queue occupancy stays within the queue depths.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((urgent_count <= UCW'(URGENT_DEPTH)) &&
		(normal_count <= NCW'(NORMAL_DEPTH))))
		else $error("queue occupancy above depth");

endmodule
`default_nettype wire

/* design/tpcd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tpcd_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* design/tpcd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_front: input side of the dispatcher
// Takes stream transfers, decodes the item kind and holds up to two items
// for the back end, so the input keeps flowing while the back end works.
// ----------------------------------------------------------------------------
module tpcd_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [tpcd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input wire logic [tpcd_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	output logic item_valid,
	output tpcd_pkg::item_t item,
	input wire logic item_pop
);
	import tpcd_pkg::*;

	item_t slot_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic push;
	item_t item_in;

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push = s_axis_tvalid && s_axis_tready;
	assign item_valid = (cnt_q != 2'd0);
	assign item = slot_q[rd_q];

	always_comb begin
		item_in.kind = kind_t'(s_axis_tuser);
		item_in.cmd.id = s_axis_tdata[15:0];
		item_in.cmd.ctype = s_axis_tdata[18:16];
		item_in.cmd.dur = s_axis_tdata[26:19];
		item_in.cmd.speed = s_axis_tdata[33:27];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (item_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_pop};
		end
	end

endmodule
`default_nettype wire

/* design/tpcd_cmdq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_cmdq: command FIFO
// Circular buffer over a RAM; pop data is registered and appears in the cycle after the pop.
// ----------------------------------------------------------------------------
module tpcd_cmdq #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire tpcd_pkg::q_ctrl_t ctrl,
	input wire tpcd_pkg::cmd_t wdata,
	output tpcd_pkg::cmd_t rdata,
	output logic [CW-1:0] count,
	output logic full
);
	import tpcd_pkg::*;

	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;
	logic [$bits(cmd_t)-1:0] ram_rdata;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
		wrap_inc = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
	endfunction

	assign full = (count_q == CW'(DEPTH));
	assign count = count_q;
	assign do_push = ctrl.push && !full;
	assign do_pop = ctrl.pop && (count_q != '0);

	tpcd_ram #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(do_push),
		.waddr(tail_q),
		.wdata(wdata),
		.re(do_pop),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	assign rdata = cmd_t'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= wrap_inc(tail_q);
			end
			if (do_pop) begin
				head_q <= wrap_inc(head_q);
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule
`default_nettype wire

/* design/tpcd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_back: execution side of the dispatcher
// Sequencer that carries out ticks, pushes and obstacle events against the
// two command queues and drives the registered result.
// ----------------------------------------------------------------------------
module tpcd_back #(
	parameter int URGENT_DEPTH = 8,
	parameter int NORMAL_DEPTH = 16,
	localparam int UCW = $clog2(URGENT_DEPTH + 1),
	localparam int NCW = $clog2(NORMAL_DEPTH + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire tpcd_pkg::cfg_t cfg,
	input wire logic item_valid,
	input wire tpcd_pkg::item_t item,
	output logic item_pop,
	output logic m_valid,
	input wire logic m_ready,
	output tpcd_pkg::res_t res,
	output logic [NCW-1:0] normal_count,
	output logic [UCW-1:0] urgent_count
);
	import tpcd_pkg::*;

	bk_state_t state_q;
	bk_state_t state_n;

	cmd_t active_q;
	cmd_t active_d;
	logic act_urg_q;
	logic act_urg_d;
	logic executing_q;
	logic executing_d;
	logic [REM_W-1:0] remaining_q;
	logic [REM_W-1:0] remaining_d;
	logic [6:0] battery_q;
	logic [6:0] battery_d;
	logic [HOLD_W-1:0] hold_q;
	logic [HOLD_W-1:0] hold_d;
	logic drop_q;
	logic drop_d;
	logic pop_urg_q;
	logic pop_urg_d;
	logic alert_keep_q;
	logic alert_keep_d;

	logic out_valid_q;
	res_t out_res_q;
	logic [NCW-1:0] out_ncnt_q;
	logic [UCW-1:0] out_ucnt_q;

	q_ctrl_t u_ctrl;
	q_ctrl_t n_ctrl;
	cmd_t u_wdata;
	cmd_t u_rdata;
	cmd_t n_rdata;
	cmd_t pop_data;
	logic [UCW-1:0] ucount;
	logic [NCW-1:0] ncount;
	logic ufull;
	logic nfull;
	logic [UCW-1:0] u_cnt_nxt;
	logic [NCW-1:0] n_cnt_nxt;

	logic out_free;
	logic start;
	logic low_batt;
	logic [6:0] bat_restored;
	logic [6:0] bat_after_cost;
	logic tick_has_work;
	logic emit;
	ev_t ev_d;
	logic alert_d;

	tpcd_cmdq #(.DEPTH(URGENT_DEPTH)) u_urgent_q (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(u_ctrl),
		.wdata(u_wdata),
		.rdata(u_rdata),
		.count(ucount),
		.full(ufull)
	);

	tpcd_cmdq #(.DEPTH(NORMAL_DEPTH)) u_normal_q (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(n_ctrl),
		.wdata(item.cmd),
		.rdata(n_rdata),
		.count(ncount),
		.full(nfull)
	);

	assign out_free = !out_valid_q || m_ready;
	assign start = (state_q == BK_IDLE) && item_valid && out_free;
	assign low_batt = battery_q < cfg.low_battery_level;
	assign bat_restored = low_batt ? BATTERY_FULL : battery_q;
	assign bat_after_cost = (bat_restored > cfg.battery_cost) ?
		bat_restored - cfg.battery_cost : 7'd0;
	assign tick_has_work = low_batt || (ucount != '0) || (ncount != '0);
	assign pop_data = pop_urg_q ? u_rdata : n_rdata;
	assign u_cnt_nxt = ucount + UCW'(u_ctrl.push && !ufull) - UCW'(u_ctrl.pop);
	assign n_cnt_nxt = ncount + NCW'(n_ctrl.push && !nfull) - NCW'(n_ctrl.pop);

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start) begin
					unique case (item.kind)
						KIND_TICK: begin
							if (!executing_q && tick_has_work) begin
								state_n = BK_POP_RD;
							end
						end
						KIND_OBSTACLE: begin
							if (hold_q == '0) begin
								state_n = BK_OBS2;
							end
						end
						KIND_PUSH_NORMAL, KIND_PUSH_URGENT: begin
							state_n = BK_IDLE;
						end
					endcase
				end
			end
			BK_POP_RD: state_n = BK_POP_LD;
			BK_POP_LD: state_n = BK_IDLE;
			BK_OBS2: state_n = BK_IDLE;
		endcase
	end

	// Queue controls, datapath updates and result.
	always_comb begin
		item_pop = 1'b0;
		u_ctrl = '0;
		n_ctrl = '0;
		u_wdata = item.cmd;
		emit = 1'b0;
		ev_d = EV_NONE;
		alert_d = 1'b0;
		active_d = active_q;
		act_urg_d = act_urg_q;
		executing_d = executing_q;
		remaining_d = remaining_q;
		battery_d = battery_q;
		hold_d = hold_q;
		drop_d = drop_q;
		pop_urg_d = pop_urg_q;
		alert_keep_d = alert_keep_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start) begin
					item_pop = 1'b1;
					unique case (item.kind)
						KIND_TICK: begin
							if (hold_q != '0) begin
								hold_d = hold_q - HOLD_W'(1);
							end
							if (low_batt) begin
								u_ctrl.push = !ufull;
								u_wdata = CMD_RECHARGE;
								alert_d = 1'b1;
							end
							battery_d = bat_restored;
							if (executing_q) begin
								emit = 1'b1;
								if (remaining_q <= REM_W'(1)) begin
									remaining_d = '0;
									executing_d = 1'b0;
									ev_d = EV_FINISHED;
									if (active_q.ctype != TYPE_CHARGE) begin
										battery_d = bat_after_cost;
									end
								end else begin
									remaining_d = remaining_q - REM_W'(1);
								end
							end else if (tick_has_work) begin
								// The recharge command just injected counts as urgent.
								pop_urg_d = low_batt || (ucount != '0);
								alert_keep_d = low_batt;
							end else begin
								emit = 1'b1;
							end
						end
						KIND_PUSH_NORMAL: begin
							n_ctrl.push = !nfull;
							ev_d = nfull ? EV_DROPPED : EV_NONE;
							emit = 1'b1;
						end
						KIND_PUSH_URGENT: begin
							u_ctrl.push = !ufull;
							ev_d = ufull ? EV_DROPPED : EV_NONE;
							emit = 1'b1;
						end
						KIND_OBSTACLE: begin
							if (hold_q == '0) begin
								u_ctrl.push = !ufull;
								u_wdata = CMD_STOP;
								drop_d = ufull;
								hold_d = HOLD_W'(cfg.obstacle_hold_units) *
									HOLD_W'(cfg.ticks_per_unit);
							end else begin
								emit = 1'b1;
							end
						end
					endcase
				end
			end
			BK_POP_RD: begin
				u_ctrl.pop = pop_urg_q;
				n_ctrl.pop = !pop_urg_q;
			end
			BK_POP_LD: begin
				active_d = pop_data;
				act_urg_d = pop_urg_q;
				remaining_d = REM_W'(pop_data.dur) * REM_W'(cfg.ticks_per_unit);
				executing_d = 1'b1;
				ev_d = EV_STARTED;
				alert_d = alert_keep_q;
				emit = 1'b1;
			end
			BK_OBS2: begin
				u_ctrl.push = !ufull;
				u_wdata = CMD_REVERSE;
				ev_d = (drop_q || ufull) ? EV_DROPPED : EV_NONE;
				emit = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			active_q <= '0;
			act_urg_q <= 1'b0;
			executing_q <= 1'b0;
			remaining_q <= '0;
			battery_q <= BATTERY_FULL;
			hold_q <= '0;
			drop_q <= 1'b0;
			pop_urg_q <= 1'b0;
			alert_keep_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			active_q <= active_d;
			act_urg_q <= act_urg_d;
			executing_q <= executing_d;
			remaining_q <= remaining_d;
			battery_q <= battery_d;
			hold_q <= hold_d;
			drop_q <= drop_d;
			pop_urg_q <= pop_urg_d;
			alert_keep_q <= alert_keep_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_res_q.ev <= ev_d;
			out_res_q.id <= active_d.id;
			out_res_q.ctype <= active_d.ctype;
			out_res_q.speed <= active_d.speed;
			out_res_q.urgent <= act_urg_d;
			out_res_q.busy <= executing_d;
			out_res_q.battery <= battery_d;
			out_res_q.alert <= alert_d;
			out_ncnt_q <= n_cnt_nxt;
			out_ucnt_q <= u_cnt_nxt;
		end
	end

	assign m_valid = out_valid_q;
	assign res = out_res_q;
	assign normal_count = out_ncnt_q;
	assign urgent_count = out_ucnt_q;

endmodule
`default_nettype wire
